>>> rtl/lkvc_pkg.sv
// Shared types and constants for the LRU key-value cache.
package lkvc_pkg;

	localparam int ENTRIES_DEF    = 16;
	localparam int KEY_BITS_DEF   = 64;
	localparam int VALUE_BITS_DEF = 64;

	localparam int KIND_W    = 2;
	localparam int KEY_W     = 64;
	localparam int VALUE_W   = 64;
	localparam int VERSION_W = 64;
	localparam int CAP_W     = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Request kinds; the fourth code is unused and leaves the cache alone.
	typedef enum logic [KIND_W-1:0] {
		KIND_GET   = 2'd0,
		KIND_SET   = 2'd1,
		KIND_CLEAR = 2'd2
	} kind_t;

	// Sequencer states of the top level.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_COMMIT
	} state_t;

	// What a cell loads at the next edge.
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_FROM_PREV,
		CELL_FROM_NEXT
	} cell_op_t;

endpackage

>>> rtl/lkvc_if.sv
// Request and response channel interfaces of the LRU key-value cache.
interface lkvc_req_if
	import lkvc_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [KIND_W-1:0]    kind;
	logic [KEY_W-1:0]     key;
	logic [VALUE_W-1:0]   value;
	logic [VERSION_W-1:0] version;

	modport source (output valid, kind, key, value, version, input ready);
	modport sink (input valid, kind, key, value, version, output ready);
endinterface

interface lkvc_rsp_if
	import lkvc_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic                 hit;
	logic [VALUE_W-1:0]   value_out;
	logic [VERSION_W-1:0] version_out;

	modport source (output valid, hit, value_out, version_out, input ready);
	modport sink (input valid, hit, value_out, version_out, output ready);
endinterface

>>> rtl/lkvc_cell.sv
// One cache slot of the recency chain: holds an entry and shifts it to a neighbor.
module lkvc_cell
	import lkvc_pkg::*;
#(
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cell_op_t              op,
	input  logic [KEY_BITS-1:0]   lookup_key,
	input  logic                  prev_valid,
	input  logic [KEY_BITS-1:0]   prev_key,
	input  logic [VALUE_BITS-1:0] prev_value,
	input  logic [VERSION_W-1:0]  prev_version,
	input  logic                  next_valid,
	input  logic [KEY_BITS-1:0]   next_key,
	input  logic [VALUE_BITS-1:0] next_value,
	input  logic [VERSION_W-1:0]  next_version,
	output logic                  valid,
	output logic [KEY_BITS-1:0]   key,
	output logic [VALUE_BITS-1:0] value,
	output logic [VERSION_W-1:0]  version,
	output logic                  match
);

	logic                  valid_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [VERSION_W-1:0]  version_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (op)
				CELL_FROM_PREV: valid_q <= prev_valid;
				CELL_FROM_NEXT: valid_q <= next_valid;
				default:        valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			CELL_FROM_PREV: begin
				key_q     <= prev_key;
				value_q   <= prev_value;
				version_q <= prev_version;
			end
			CELL_FROM_NEXT: begin
				key_q     <= next_key;
				value_q   <= next_value;
				version_q <= next_version;
			end
			default: begin
				key_q     <= key_q;
				value_q   <= value_q;
				version_q <= version_q;
			end
		endcase
	end

	assign valid   = valid_q;
	assign key     = key_q;
	assign value   = value_q;
	assign version = version_q;
	assign match   = valid_q && (key_q == lookup_key);

endmodule

>>> rtl/lru_key_value_cache_unit.sv
// Top level of the fully associative LRU key-value cache.
//
// Requests arrive as words on the req channel (kind, key, value, version) and each
// one produces exactly one word on the rsp channel (hit, value_out, version_out).
// A word moves when valid and ready are both high at a rising clock edge.
// The user writes the capacity limit through cfg_we / cfg_wdata only while the cache is
// idle; the block does not enforce it. Zero acts as one, values above ENTRIES as ENTRIES.
//
// The entries live in a chain of cells kept in recency order: cell 0 is the most
// recent entry and valid entries always sit packed at the low end of the chain.
// A request is served in steps: the accept edge loads the request register, the
// next cycle compares the key against every cell in parallel and registers the
// match position, and the commit cycle shifts the chain (toward the tail to bring
// an entry or a new one to the front, toward the head to close the gap of a clear)
// and loads the response register. One request is in flight at a time, so a new
// request is accepted only after the commit of the last one.
// A response waiting in the output register does not block the next accept; if it
// is still not taken when the next commit is due, the commit waits for it.
// Reset clears every valid mark, the entry count and the response valid flag, and
// sets the capacity limit to sixteen.
module lru_key_value_cache_unit
	import lkvc_pkg::*;
#(
	parameter int ENTRIES    = ENTRIES_DEF,
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	lkvc_req_if.sink         req,
	lkvc_rsp_if.source       rsp
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	// Control state.
	state_t           state_q, state_d;
	logic [CAP_W-1:0] limit_q;
	logic [CNT_W-1:0] count_q;
	logic             rsp_valid_q;

	// Request being served.
	logic [KIND_W-1:0]     req_kind_q;
	logic [KEY_BITS-1:0]   req_key_q;
	logic [VALUE_BITS-1:0] req_value_q;
	logic [VERSION_W-1:0]  req_version_q;

	// Lookup results, registered at the end of the compare cycle.
	logic                  hit_s1;
	logic [IDX_W-1:0]      hit_idx_s1;
	logic [VALUE_BITS-1:0] hit_value_s1;
	logic [VERSION_W-1:0]  hit_version_s1;

	// Response register payload.
	logic                 rsp_hit_q;
	logic [VALUE_W-1:0]   rsp_value_q;
	logic [VERSION_W-1:0] rsp_version_q;

	// Chain wiring.
	cell_op_t              cell_op    [ENTRIES];
	logic                  cell_valid [ENTRIES];
	logic [KEY_BITS-1:0]   cell_key   [ENTRIES];
	logic [VALUE_BITS-1:0] cell_value [ENTRIES];
	logic [VERSION_W-1:0]  cell_ver   [ENTRIES];
	logic [ENTRIES-1:0]    cell_match;

	// Entry written into the head of the chain.
	logic [VALUE_BITS-1:0] front_value;
	logic [VERSION_W-1:0]  front_version;

	logic             accept;
	logic             commit;
	logic             is_get, is_set, is_clear;
	logic             do_front, do_clear, evict, grow;
	logic [IDX_W-1:0] src_idx;
	logic [LIM_W-1:0] lim_ext, count_ext;

	logic                  look_hit;
	logic [IDX_W-1:0]      look_idx;
	logic [VALUE_BITS-1:0] look_value;
	logic [VERSION_W-1:0]  look_version;

	assign accept = req.valid && req.ready;
	assign is_get   = (req_kind_q == KIND_GET);
	assign is_set   = (req_kind_q == KIND_SET);
	assign is_clear = (req_kind_q == KIND_CLEAR);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (accept) state_d = ST_LOOK;
			ST_LOOK:   state_d = ST_COMMIT;
			ST_COMMIT: if (commit) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		req.ready = 1'b0;
		commit    = 1'b0;
		case (state_q)
			ST_IDLE:   req.ready = 1'b1;
			ST_COMMIT: commit = !rsp_valid_q || rsp.ready;
			default: begin
				req.ready = 1'b0;
				commit    = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= CAP_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_kind_q    <= req.kind;
			req_key_q     <= req.key[KEY_BITS-1:0];
			req_value_q   <= req.value[VALUE_BITS-1:0];
			req_version_q <= req.version;
		end
	end

	// Parallel match: keys are unique, so at most one cell matches and an OR
	// over the masked entries selects its position and payload.
	always_comb begin
		look_hit     = |cell_match;
		look_idx     = '0;
		look_value   = '0;
		look_version = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (cell_match[i]) begin
				look_idx     = look_idx | IDX_W'(i);
				look_value   = look_value | cell_value[i];
				look_version = look_version | cell_ver[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOOK) begin
			hit_s1         <= look_hit;
			hit_idx_s1     <= look_idx;
			hit_value_s1   <= look_value;
			hit_version_s1 <= look_version;
		end
	end

	// A missing set evicts the tail entry once the occupancy reaches the limit.
	// A full chain always evicts, which covers limits above ENTRIES.
	assign lim_ext   = (limit_q == '0) ? LIM_W'(1) : LIM_W'(limit_q);
	assign count_ext = LIM_W'(count_q);
	assign evict     = (count_ext >= lim_ext) || (count_q == CNT_W'(ENTRIES));

	assign do_front = (is_get && hit_s1) || is_set;
	assign do_clear = is_clear && hit_s1;
	assign grow     = is_set && !hit_s1 && !evict;

	// Deepest cell that takes part in the shift toward the tail.
	always_comb begin
		if (hit_s1) begin
			src_idx = hit_idx_s1;
		end else if (evict) begin
			src_idx = IDX_W'(count_q - CNT_W'(1));
		end else begin
			src_idx = IDX_W'(count_q);
		end
	end

	assign front_value   = is_get ? hit_value_s1 : req_value_q;
	assign front_version = is_get ? hit_version_s1 : req_version_q;

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			cell_op[i] = CELL_HOLD;
			if (commit && do_front && (IDX_W'(i) <= src_idx)) begin
				cell_op[i] = CELL_FROM_PREV;
			end else if (commit && do_clear && (IDX_W'(i) >= hit_idx_s1)) begin
				cell_op[i] = CELL_FROM_NEXT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (commit) begin
			if (grow) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_clear) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		logic                  pv, nv;
		logic [KEY_BITS-1:0]   pk, nk;
		logic [VALUE_BITS-1:0] pd, nd;
		logic [VERSION_W-1:0]  pr, nr;

		if (g == 0) begin : g_head
			assign pv = 1'b1;
			assign pk = req_key_q;
			assign pd = front_value;
			assign pr = front_version;
		end else begin : g_body
			assign pv = cell_valid[g-1];
			assign pk = cell_key[g-1];
			assign pd = cell_value[g-1];
			assign pr = cell_ver[g-1];
		end

		if (g == ENTRIES - 1) begin : g_tail
			assign nv = 1'b0;
			assign nk = '0;
			assign nd = '0;
			assign nr = '0;
		end else begin : g_link
			assign nv = cell_valid[g+1];
			assign nk = cell_key[g+1];
			assign nd = cell_value[g+1];
			assign nr = cell_ver[g+1];
		end

		lkvc_cell #(
			.KEY_BITS   (KEY_BITS),
			.VALUE_BITS (VALUE_BITS)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.op           (cell_op[g]),
			.lookup_key   (req_key_q),
			.prev_valid   (pv),
			.prev_key     (pk),
			.prev_value   (pd),
			.prev_version (pr),
			.next_valid   (nv),
			.next_key     (nk),
			.next_value   (nd),
			.next_version (nr),
			.valid        (cell_valid[g]),
			.key          (cell_key[g]),
			.value        (cell_value[g]),
			.version      (cell_ver[g]),
			.match        (cell_match[g])
		);
	end

	// Response register: the payload is only ever loaded by a commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rsp_hit_q     <= hit_s1 && (is_get || is_set || is_clear);
			rsp_value_q   <= (is_get && hit_s1) ? VALUE_W'(hit_value_s1) : '0;
			rsp_version_q <= (is_get && hit_s1) ? hit_version_s1 : '0;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.hit         = rsp_hit_q;
	assign rsp.value_out   = rsp_value_q;
	assign rsp.version_out = rsp_version_q;

endmodule
